### hw/rtl/multi_sensor_distance_selector_macros.svh
// assertion macros shared by the checker of the distance selector
`ifndef MULTI_SENSOR_DISTANCE_SELECTOR_MACROS_SVH
`define MULTI_SENSOR_DISTANCE_SELECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is low
`define MSDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while reset is low
`define MSDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/msds_pkg.sv
// shared constants, codes and types of the distance selector
`default_nettype none
package msds_pkg;
	localparam int MAX_REMOTES = 4;
	localparam int CNT_W = $clog2(MAX_REMOTES + 1);

	localparam int DIST_W = 9;
	localparam int TIME_W = 32;
	localparam int LIMIT_W = 13;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(500);
	localparam logic [LIMIT_W-1:0] AGE_LIMIT = LIMIT_W'(5000);
	localparam logic [LIMIT_W-1:0] ZONE_AGE_LIMIT = LIMIT_W'(4000);
	localparam logic [LIMIT_W-1:0] HYSTERESIS_MS = LIMIT_W'(2000);
	localparam logic [LIMIT_W-1:0] FADE_IDLE_MS = LIMIT_W'(3000);
	localparam logic [DIST_W:0] FADE_STEP = (DIST_W + 1)'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 3'd0,
		REG_MIN = 3'd1,
		REG_MAX = 3'd2,
		REG_COUNT = 3'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_RECENT = 2'd0,
		MODE_REMOTE = 2'd1,
		MODE_LOCAL = 2'd2,
		MODE_ZONE = 2'd3
	} mode_t;

	// result of the shared age unit
	typedef struct packed {
		logic [TIME_W-1:0] diff;
		logic over_limit;
		logic below_ref;
	} age_res_t;
endpackage
`default_nettype wire

### hw/rtl/msds_entry_file.sv
// per-sensor storage of the last valid distance and its arrival time
`default_nettype none
module msds_entry_file (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [msds_pkg::CNT_W-1:0] wr_idx,
	input wire logic [msds_pkg::DIST_W-1:0] wr_dist,
	input wire logic [msds_pkg::TIME_W-1:0] wr_time,
	input wire logic [msds_pkg::CNT_W-1:0] rd_idx,
	output logic [msds_pkg::DIST_W-1:0] rd_dist,
	output logic [msds_pkg::TIME_W-1:0] rd_time
);
	logic [msds_pkg::DIST_W-1:0] dist_q [1:msds_pkg::MAX_REMOTES];
	logic [msds_pkg::TIME_W-1:0] time_q [1:msds_pkg::MAX_REMOTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= msds_pkg::MAX_REMOTES; i++) begin
				dist_q[i] <= '0;
				time_q[i] <= '0;
			end
		end else if (wr_en) begin
			dist_q[wr_idx] <= wr_dist;
			time_q[wr_idx] <= wr_time;
		end
	end

	assign rd_dist = dist_q[rd_idx];
	assign rd_time = time_q[rd_idx];
endmodule
`default_nettype wire

### hw/rtl/msds_age_unit.sv
// shared modulo-2^32 subtractor with limit and reference compares
`default_nettype none
module msds_age_unit (
	input wire logic [msds_pkg::TIME_W-1:0] now,
	input wire logic [msds_pkg::TIME_W-1:0] stamp,
	input wire logic [msds_pkg::LIMIT_W-1:0] limit,
	input wire logic [msds_pkg::TIME_W-1:0] ref_age,
	output msds_pkg::age_res_t res
);
	logic [msds_pkg::TIME_W-1:0] diff;

	assign diff = now - stamp;

	always_comb begin
		res.diff = diff;
		res.over_limit = diff > msds_pkg::TIME_W'(limit);
		res.below_ref = diff < ref_age;
	end
endmodule
`default_nettype wire

### hw/rtl/multi_sensor_distance_selector.sv
// top level of the multi-sensor distance selector
// A transaction is taken at a clock edge with start high and busy low. A report whose
// distance lies outside 0..500 is dropped there: busy stays low and no result follows.
// A valid report from sensor 1..MAX_REMOTES is stored with now_ms as its arrival time,
// then one shared subtract-and-compare unit walks the stored sensors, one per cycle,
// to find the freshest counting remote; in zone mode the same unit then checks the
// hysteresis or fade interval in its own zone state. The chosen and clamped distance shows
// up on selected_distance and using_remote for exactly one cycle with result_valid
// high, and the receiver cannot stall it. From acceptance an item passes the scan state
// once per remote, up to remote_count capped at MAX_REMOTES, then the zone state in
// zone mode and the output state before the strobe; the next transaction may be
// started in the strobe cycle itself. Configuration writes are taken whenever busy is
// low and should be issued only while no item is in flight.
`default_nettype none
module multi_sensor_distance_selector (
	input wire logic clk,
	input wire logic arst_n,
	// item channel
	input wire logic start,
	output logic busy,
	input wire logic [7:0] sensor_index,
	input wire logic signed [15:0] reported_distance,
	input wire logic [31:0] now_ms,
	input wire logic [8:0] local_distance,
	// result channel
	output logic result_valid,
	output logic [8:0] selected_distance,
	output logic using_remote,
	// configuration write channel
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [msds_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [8:0] cfg_data
);
	localparam int CNT_W = msds_pkg::CNT_W;
	localparam int DIST_W = msds_pkg::DIST_W;
	localparam int TIME_W = msds_pkg::TIME_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_ZONE = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	msds_pkg::mode_t mode_q;
	logic [DIST_W-1:0] min_q;
	logic [DIST_W-1:0] max_q;
	logic [2:0] count_q;

	// zone tracking state
	logic zone_active_q;
	logic [TIME_W-1:0] zone_switch_q;
	logic [DIST_W-1:0] zone_last_q;
	logic zone_ready_q;

	// per-item working registers
	logic [CNT_W-1:0] cnt_q;
	logic found_q;
	logic [TIME_W-1:0] best_age_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [TIME_W-1:0] now_q;
	logic [DIST_W-1:0] local_q;

	// result registers
	logic result_valid_q;
	logic [DIST_W-1:0] sel_q;
	logic using_q;

	logic accept;
	logic rep_ok;
	logic idx_ok;
	logic store_wr;
	logic [CNT_W-1:0] scan_n;
	logic [DIST_W-1:0] rd_dist;
	logic [TIME_W-1:0] rd_time;
	logic [TIME_W-1:0] unit_stamp;
	logic [msds_pkg::LIMIT_W-1:0] unit_limit;
	msds_pkg::age_res_t unit_res;
	logic counts;
	logic scan_last;
	state_t after_scan;
	logic [DIST_W:0] fade_sum;
	logic [DIST_W-1:0] fade_val;
	logic [DIST_W-1:0] pick;
	logic [DIST_W-1:0] clamped;

	assign busy = state_q != ST_IDLE;
	assign cfg_ready = !busy;
	assign accept = start && !busy;

	// report range check: signed value within 0..500
	assign rep_ok = !reported_distance[15]
		&& (reported_distance[14:0] <= 15'(msds_pkg::DIST_LIMIT));
	assign idx_ok = (sensor_index != 8'd0)
		&& (32'(sensor_index) <= msds_pkg::MAX_REMOTES);
	assign store_wr = accept && rep_ok && idx_ok;

	// number of remotes to scan, capped at the storage depth
	always_comb begin
		if (32'(count_q) > msds_pkg::MAX_REMOTES) begin
			scan_n = CNT_W'(msds_pkg::MAX_REMOTES);
		end else begin
			scan_n = CNT_W'(count_q);
		end
	end

	msds_entry_file u_entries (
		.clk (clk),
		.arst_n (arst_n),
		.wr_en (store_wr),
		.wr_idx (CNT_W'(sensor_index)),
		.wr_dist (reported_distance[DIST_W-1:0]),
		.wr_time (now_ms),
		.rd_idx (cnt_q),
		.rd_dist (rd_dist),
		.rd_time (rd_time)
	);

	// shared unit: sensor age while scanning, time since last switch in zone step
	always_comb begin
		if (state_q == ST_ZONE) begin
			unit_stamp = zone_switch_q;
			unit_limit = (local_q != '0) ? msds_pkg::HYSTERESIS_MS : msds_pkg::FADE_IDLE_MS;
		end else begin
			unit_stamp = rd_time;
			unit_limit = (mode_q == msds_pkg::MODE_ZONE) ? msds_pkg::ZONE_AGE_LIMIT
				: msds_pkg::AGE_LIMIT;
		end
	end

	msds_age_unit u_age (
		.now (now_q),
		.stamp (unit_stamp),
		.limit (unit_limit),
		.ref_age (best_age_q),
		.res (unit_res)
	);

	// a remote counts when fresh and nonzero; ties keep the lower sensor number
	assign counts = !unit_res.over_limit && (rd_dist != '0);
	assign scan_last = cnt_q == scan_n;
	assign after_scan = (mode_q == msds_pkg::MODE_ZONE) ? ST_ZONE : ST_OUT;

	// fade by two, capped at max_distance
	assign fade_sum = {1'b0, zone_last_q} + msds_pkg::FADE_STEP;
	assign fade_val = (fade_sum < {1'b0, max_q}) ? fade_sum[DIST_W-1:0] : max_q;

	// mode selection; most recent and local first pick the same way
	always_comb begin
		case (mode_q)
			msds_pkg::MODE_REMOTE: begin
				pick = found_q ? best_dist_q : local_q;
			end
			msds_pkg::MODE_ZONE: begin
				pick = zone_last_q;
			end
			default: begin
				pick = (local_q != '0) ? local_q : (found_q ? best_dist_q : local_q);
			end
		endcase
	end

	// clamp, lower bound first; an inverted range gives min_q below min_q, else max_q
	always_comb begin
		if (pick < min_q) begin
			clamped = min_q;
		end else if (pick > max_q) begin
			clamped = max_q;
		end else begin
			clamped = pick;
		end
	end

	// control, configuration and zone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= msds_pkg::MODE_RECENT;
			min_q <= '0;
			max_q <= msds_pkg::DIST_LIMIT;
			count_q <= '0;
			zone_active_q <= 1'b0;
			zone_switch_q <= '0;
			zone_last_q <= '0;
			zone_ready_q <= 1'b0;
			cnt_q <= '0;
			found_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					msds_pkg::REG_MODE: begin
						mode_q <= msds_pkg::mode_t'(cfg_data[1:0]);
						zone_ready_q <= 1'b0;
					end
					msds_pkg::REG_MIN: begin
						min_q <= cfg_data;
					end
					msds_pkg::REG_MAX: begin
						max_q <= cfg_data;
					end
					msds_pkg::REG_COUNT: begin
						count_q <= cfg_data[2:0];
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && rep_ok) begin
						found_q <= 1'b0;
						cnt_q <= CNT_W'(1);
						// first zone transaction seeds the tracker
						if (mode_q == msds_pkg::MODE_ZONE && !zone_ready_q) begin
							zone_active_q <= 1'b0;
							zone_switch_q <= now_ms;
							zone_last_q <= local_distance;
							zone_ready_q <= 1'b1;
						end
						if (scan_n == '0) begin
							state_q <= after_scan;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (counts && (!found_q || unit_res.below_ref)) begin
						found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= after_scan;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_ZONE: begin
					if (found_q) begin
						if (!zone_active_q) begin
							zone_active_q <= 1'b1;
							zone_switch_q <= now_q;
						end
						zone_last_q <= best_dist_q;
					end else if (local_q != '0) begin
						// switch back to local only after the hysteresis interval
						if (zone_active_q && unit_res.over_limit) begin
							zone_active_q <= 1'b0;
							zone_switch_q <= now_q;
						end
						if (!zone_active_q || unit_res.over_limit) begin
							zone_last_q <= local_q;
						end
					end else if (unit_res.over_limit) begin
						zone_last_q <= fade_val;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					result_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now_ms;
			local_q <= local_distance;
		end
		if (state_q == ST_SCAN && counts && (!found_q || unit_res.below_ref)) begin
			best_age_q <= unit_res.diff;
			best_dist_q <= rd_dist;
		end
		if (state_q == ST_OUT) begin
			sel_q <= clamped;
			using_q <= zone_active_q;
		end
	end

	assign result_valid = result_valid_q;
	assign selected_distance = sel_q;
	assign using_remote = using_q;
endmodule
`default_nettype wire

### hw/rtl/msds_checker.sv
// port-level checker of the distance selector and its bind
`default_nettype none
`include "multi_sensor_distance_selector_macros.svh"
module msds_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic signed [15:0] reported_distance,
	input wire logic result_valid
);
	logic rep_ok;

	assign rep_ok = !reported_distance[15] && (reported_distance[14:0] <= 15'd500);

	`MSDS_ASSERT_NOW(a_strobe_when_idle, result_valid, !busy, "result strobe while busy")
	`MSDS_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe longer than one cycle")
	`MSDS_ASSERT_NEXT(a_valid_goes_busy, start && !busy && rep_ok, busy, "valid report did not start work")
	`MSDS_ASSERT_NEXT(a_drop_stays_idle, start && !busy && !rep_ok, !busy && !result_valid, "dropped report started work")
endmodule

bind multi_sensor_distance_selector msds_checker u_msds_checker (
	.clk (clk),
	.arst_n (arst_n),
	.start (start),
	.busy (busy),
	.reported_distance (reported_distance),
	.result_valid (result_valid)
);
`default_nettype wire
